// File: rtl/bpt_pkg.sv
package bpt_pkg;

   localparam int COORD_BITS_DEFAULT       = 24;
   localparam int WEIGHT_FRAC_BITS_DEFAULT = 16;

   localparam logic [1:0] ST_INSIDE     = 2'd0;
   localparam logic [1:0] ST_OUTSIDE    = 2'd1;
   localparam logic [1:0] ST_DEGENERATE = 2'd2;

   // Control that travels beside the data through the pipeline.
   typedef struct packed {
      logic       valid;
      logic [1:0] status;
   } bpt_ctrl_type;

endpackage

// File: rtl/bpt_if.sv
interface bpt_req_if #(
   parameter int COORD_BITS = 24
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] vertex_a_x;
   logic signed [COORD_BITS-1:0] vertex_a_y;
   logic signed [COORD_BITS-1:0] vertex_b_x;
   logic signed [COORD_BITS-1:0] vertex_b_y;
   logic signed [COORD_BITS-1:0] vertex_c_x;
   logic signed [COORD_BITS-1:0] vertex_c_y;

   modport source (
      output valid, point_x, point_y, vertex_a_x, vertex_a_y,
             vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, vertex_a_x, vertex_a_y,
             vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
      output ready
   );
endinterface

interface bpt_rsp_if #(
   parameter int WEIGHT_FRAC_BITS = 16
);
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic [WEIGHT_FRAC_BITS:0] weight_a;
   logic [WEIGHT_FRAC_BITS:0] weight_b;
   logic [WEIGHT_FRAC_BITS:0] weight_c;

   modport source (
      output valid, status, weight_a, weight_b, weight_c,
      input  ready
   );
   modport sink (
      input  valid, status, weight_a, weight_b, weight_c,
      output ready
   );
endinterface

// File: rtl/bpt_front.sv
module bpt_front #(
   parameter int COORD_BITS = 24,
   parameter int CROSS_BITS = 2 * (COORD_BITS + 1) + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [COORD_BITS-1:0]  px,
   input  logic signed [COORD_BITS-1:0]  py,
   input  logic signed [COORD_BITS-1:0]  ax,
   input  logic signed [COORD_BITS-1:0]  ay,
   input  logic signed [COORD_BITS-1:0]  bx,
   input  logic signed [COORD_BITS-1:0]  by,
   input  logic signed [COORD_BITS-1:0]  cx,
   input  logic signed [COORD_BITS-1:0]  cy,
   output bpt_pkg::bpt_ctrl_type         ctrl,
   output logic [CROSS_BITS-1:0]         den_mag,
   output logic [CROSS_BITS-1:0]         na_mag,
   output logic [CROSS_BITS-1:0]         nb_mag
);
   import bpt_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [DW-1:0] v0x_ff, v0y_ff, v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic signed [PW-1:0] pd0_ff, pd1_ff, pa0_ff, pa1_ff, pb0_ff, pb1_ff;
   logic signed [CROSS_BITS-1:0] den_ff, na_ff, nb_ff;
   logic signed [CROSS_BITS-1:0] den_in, na_in, nb_in;
   logic signed [CROSS_BITS:0]   sum_in;
   logic [1:0]                   status_in, status_ff;
   logic [CROSS_BITS-1:0]        dm_ff, am_ff, bm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Edge vectors from vertex a, then the six products, then the crosses.
   always_ff @(posedge clock) begin
      if (adv) begin
         v0x_ff <= DW'(bx) - DW'(ax);
         v0y_ff <= DW'(by) - DW'(ay);
         v1x_ff <= DW'(cx) - DW'(ax);
         v1y_ff <= DW'(cy) - DW'(ay);
         v2x_ff <= DW'(px) - DW'(ax);
         v2y_ff <= DW'(py) - DW'(ay);
         pd0_ff <= PW'(v0x_ff) * PW'(v1y_ff);
         pd1_ff <= PW'(v0y_ff) * PW'(v1x_ff);
         pa0_ff <= PW'(v2x_ff) * PW'(v1y_ff);
         pa1_ff <= PW'(v2y_ff) * PW'(v1x_ff);
         pb0_ff <= PW'(v0x_ff) * PW'(v2y_ff);
         pb1_ff <= PW'(v0y_ff) * PW'(v2x_ff);
         den_ff <= CROSS_BITS'(pd0_ff) - CROSS_BITS'(pd1_ff);
         na_ff  <= CROSS_BITS'(pa0_ff) - CROSS_BITS'(pa1_ff);
         nb_ff  <= CROSS_BITS'(pb0_ff) - CROSS_BITS'(pb1_ff);
      end
   end

   // Fold the sign of the determinant into the numerators and classify.
   always_comb begin
      den_in = den_ff[CROSS_BITS-1] ? -den_ff : den_ff;
      na_in  = den_ff[CROSS_BITS-1] ? -na_ff  : na_ff;
      nb_in  = den_ff[CROSS_BITS-1] ? -nb_ff  : nb_ff;
      sum_in = (CROSS_BITS+1)'(na_in) + (CROSS_BITS+1)'(nb_in);
      if (den_ff == '0) begin
         status_in = ST_DEGENERATE;
      end else if (na_in[CROSS_BITS-1] || nb_in[CROSS_BITS-1] ||
                   (sum_in > (CROSS_BITS+1)'(den_in))) begin
         status_in = ST_OUTSIDE;
      end else begin
         status_in = ST_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status_ff <= status_in;
         dm_ff     <= den_in;
         am_ff     <= na_in;
         bm_ff     <= nb_in;
      end
   end

   assign ctrl.valid  = v4_ff;
   assign ctrl.status = status_ff;
   assign den_mag     = dm_ff;
   assign na_mag      = am_ff;
   assign nb_mag      = bm_ff;

endmodule

// File: rtl/bpt_divider.sv
module bpt_divider #(
   parameter int CROSS_BITS       = 51,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [CROSS_BITS-1:0]       num,
   input  logic [CROSS_BITS-1:0]       den,
   output logic [WEIGHT_FRAC_BITS:0]   quot
);
   localparam int STAGES = WEIGHT_FRAC_BITS + 1;
   localparam int RW     = CROSS_BITS + 1;

   logic [RW-1:0]               rem_ff [STAGES];
   logic [CROSS_BITS-1:0]       den_ff [STAGES];
   logic [WEIGHT_FRAC_BITS:0]   q_ff   [STAGES];

   // One quotient bit per stage, most significant first; num <= den.
   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      logic [RW-1:0]             rem_prev, shifted;
      logic [CROSS_BITS-1:0]     den_prev;
      logic [WEIGHT_FRAC_BITS:0] q_prev;
      logic                      ge;

      if (j == 0) begin : g_first
         assign rem_prev = {1'b0, num};
         assign den_prev = den;
         assign q_prev   = '0;
         assign shifted  = rem_prev;
      end else begin : g_rest
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign q_prev   = q_ff[j-1];
         assign shifted  = {rem_prev[RW-2:0], 1'b0};
      end

      assign ge = shifted >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j] <= ge ? shifted - {1'b0, den_prev} : shifted;
            den_ff[j] <= den_prev;
            q_ff[j]   <= q_prev | ((WEIGHT_FRAC_BITS+1)'(ge) << (WEIGHT_FRAC_BITS - j));
         end
      end
   end

   assign quot = q_ff[STAGES-1];

endmodule

// File: rtl/barycentric_point_in_triangle.sv
// Barycentric point-in-triangle test for one 2D query point against one
// triangle, with all coordinates signed fixed point. The
// status word says inside, outside or degenerate (zero-area triangle); for an
// inside point the three weights are unsigned Q1.WEIGHT_FRAC_BITS, with the b
// and c weights truncated and the a weight making the sum exactly one. Points on
// an edge or a vertex count as inside. All tests are exact integer arithmetic.
// The block takes a new word every cycle while the output is not held. Each
// word passes through registers for edge vectors, products, cross products
// and classification, then through the stages of the two restoring dividers,
// most significant quotient bit first, and one output register. The pipeline
// stalls as a whole while a result waits unclaimed at the output.
module barycentric_point_in_triangle #(
   parameter int COORD_BITS       = bpt_pkg::COORD_BITS_DEFAULT,
   parameter int WEIGHT_FRAC_BITS = bpt_pkg::WEIGHT_FRAC_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   bpt_req_if.sink   req,
   bpt_rsp_if.source rsp
);
   import bpt_pkg::*;

   localparam int CROSS_BITS = 2 * (COORD_BITS + 1) + 1;
   localparam int WW         = WEIGHT_FRAC_BITS + 1;
   localparam int DIV_STAGES = WEIGHT_FRAC_BITS + 1;

   logic                  adv;
   bpt_ctrl_type          front_ctrl;
   bpt_ctrl_type          ctrl_ff [DIV_STAGES];
   logic [CROSS_BITS-1:0] den_mag, na_mag, nb_mag;
   logic [WW-1:0]         wb_q, wc_q;
   logic                  out_valid_ff;
   logic [1:0]            status_ff;
   logic [WW-1:0]         wa_ff, wb_ff, wc_ff;
   logic [WW-1:0]         wa_in;

   // The whole pipeline moves together unless the output word is held.
   assign adv       = !out_valid_ff || rsp.ready;
   assign req.ready = adv;

   bpt_front #(
      .COORD_BITS (COORD_BITS),
      .CROSS_BITS (CROSS_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req.valid),
      .px       (req.point_x),
      .py       (req.point_y),
      .ax       (req.vertex_a_x),
      .ay       (req.vertex_a_y),
      .bx       (req.vertex_b_x),
      .by       (req.vertex_b_y),
      .cx       (req.vertex_c_x),
      .cy       (req.vertex_c_y),
      .ctrl     (front_ctrl),
      .den_mag  (den_mag),
      .na_mag   (na_mag),
      .nb_mag   (nb_mag)
   );

   // The alpha quotient gives the weight of b, the beta quotient that of c.
   bpt_divider #(
      .CROSS_BITS       (CROSS_BITS),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_div_b (
      .clock (clock),
      .adv   (adv),
      .num   (na_mag),
      .den   (den_mag),
      .quot  (wb_q)
   );

   bpt_divider #(
      .CROSS_BITS       (CROSS_BITS),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_div_c (
      .clock (clock),
      .adv   (adv),
      .num   (nb_mag),
      .den   (den_mag),
      .quot  (wc_q)
   );

   // Valid and status ride alongside the divider stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            ctrl_ff[i] <= '0;
         end
      end else if (adv) begin
         ctrl_ff[0] <= front_ctrl;
         for (int i = 1; i < DIV_STAGES; i++) begin
            ctrl_ff[i] <= ctrl_ff[i-1];
         end
      end
   end

   assign wa_in = (WW'(1) << WEIGHT_FRAC_BITS) - wb_q - wc_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= ctrl_ff[DIV_STAGES-1].valid;
      end
   end

   // Weights are forced to zero unless the point is inside.
   always_ff @(posedge clock) begin
      if (adv) begin
         status_ff <= ctrl_ff[DIV_STAGES-1].status;
         if (ctrl_ff[DIV_STAGES-1].status == ST_INSIDE) begin
            wa_ff <= wa_in;
            wb_ff <= wb_q;
            wc_ff <= wc_q;
         end else begin
            wa_ff <= '0;
            wb_ff <= '0;
            wc_ff <= '0;
         end
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.status   = status_ff;
   assign rsp.weight_a = wa_ff;
   assign rsp.weight_b = wb_ff;
   assign rsp.weight_c = wc_ff;

   a_zero_unless_inside: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ST_INSIDE |->
         rsp.weight_a == '0 && rsp.weight_b == '0 && rsp.weight_c == '0)
      else $error("weights not zero for a point that is not inside");

   a_weights_sum_one: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == ST_INSIDE |->
         ((WW+2)'(rsp.weight_a) + (WW+2)'(rsp.weight_b) + (WW+2)'(rsp.weight_c))
            == ((WW+2)'(1) << WEIGHT_FRAC_BITS))
      else $error("inside weights do not sum to one");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.status == ST_INSIDE || rsp.status == ST_OUTSIDE ||
                    rsp.status == ST_DEGENERATE)
      else $error("unused status code produced");

   a_held_word: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |=> out_valid_ff && $stable(status_ff) &&
                                     $stable(wb_ff) && $stable(wc_ff))
      else $error("output word changed while stalled");

endmodule

// File: bench/barycentric_point_in_triangle_test.sv
module barycentric_point_in_triangle_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bpt_pkg::*;

   localparam int CB = 24;
   localparam int WF = 16;
   localparam int RANDOM_WORDS = 1500;

   // One request word: point, then vertices a, b, c, each as x then y.
   typedef struct {
      logic signed [CB-1:0] px, py, ax, ay, bx, by, cx, cy;
   } tri_query_type;

   typedef struct {
      logic [1:0]  status;
      logic [WF:0] wa, wb, wc;
   } tri_weights_type;

   // The scoreboard computes the exact barycentric classification of each
   // accepted request and checks returned words against the oldest one.
   class weight_scoreboard;
      tri_weights_type pending[$];
      int              errors = 0;

      function automatic tri_weights_type classify(tri_query_type q);
         tri_weights_type r;
         logic signed [127:0] v0x, v0y, v1x, v1y, v2x, v2y, den, na, nb;
         r.status = ST_INSIDE;
         r.wa = '0;
         r.wb = '0;
         r.wc = '0;
         v0x = 128'(q.bx) - 128'(q.ax);
         v0y = 128'(q.by) - 128'(q.ay);
         v1x = 128'(q.cx) - 128'(q.ax);
         v1y = 128'(q.cy) - 128'(q.ay);
         v2x = 128'(q.px) - 128'(q.ax);
         v2y = 128'(q.py) - 128'(q.ay);
         den = v0x * v1y - v0y * v1x;
         na  = v2x * v1y - v2y * v1x;
         nb  = v0x * v2y - v0y * v2x;
         if (den == 0) begin
            r.status = ST_DEGENERATE;
            return r;
         end
         if (den < 0) begin
            den = -den;
            na  = -na;
            nb  = -nb;
         end
         if (na < 0 || nb < 0 || na + nb > den) begin
            r.status = ST_OUTSIDE;
            return r;
         end
         // Numerators stay far below 2^100, so the shifted forms fit.
         r.wb = (WF+1)'((na <<< WF) / den);
         r.wc = (WF+1)'((nb <<< WF) / den);
         r.wa = (WF+1)'(1 << WF) - r.wb - r.wc;
         return r;
      endfunction

      function void note_query(tri_query_type q);
         pending.push_back(classify(q));
      endfunction

      function void check_word(tri_weights_type got);
         tri_weights_type exp;
         if (pending.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status) begin
            $error("status expected %0d actual %0d", exp.status, got.status);
            errors++;
         end
         if (got.wa !== exp.wa) begin
            $error("weight_a expected %0d actual %0d", exp.wa, got.wa);
            errors++;
         end
         if (got.wb !== exp.wb) begin
            $error("weight_b expected %0d actual %0d", exp.wb, got.wb);
            errors++;
         end
         if (got.wc !== exp.wc) begin
            $error("weight_c expected %0d actual %0d", exp.wc, got.wc);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpt_req_if #(.COORD_BITS(CB))       req ();
   bpt_rsp_if #(.WEIGHT_FRAC_BITS(WF)) rsp ();

   barycentric_point_in_triangle #(
      .COORD_BITS(CB),
      .WEIGHT_FRAC_BITS(WF)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   weight_scoreboard board = new();
   bit               sending_done = 1'b0;
   // Set by the sender to make the receiver hold off for a long stretch.
   bit               hold_rsp = 1'b0;

   // Gap lengths: mostly zero or short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random coordinate biased toward the extremes now and then, so that every
   // bit takes both values and the widest products are exercised.
   function automatic logic signed [CB-1:0] any_coord();
      case ($urandom_range(0, 7))
         0: return {1'b0, {(CB-1){1'b1}}};
         1: return {1'b1, {(CB-1){1'b0}}};
         2: return CB'($urandom_range(0, 255)) - CB'(128);
         default: return CB'($urandom);
      endcase
   endfunction

   // A random triangle and a point that is often inside it: the point is built
   // as a non-negative combination of the edge vectors.
   function automatic tri_query_type shaped_query();
      tri_query_type q;
      int unsigned   span;
      int            s, t;
      span = 1 << $urandom_range(4, 21);
      q.ax = CB'($urandom_range(0, 2 * span)) - CB'(span);
      q.ay = CB'($urandom_range(0, 2 * span)) - CB'(span);
      q.bx = CB'($urandom_range(0, 2 * span)) - CB'(span);
      q.by = CB'($urandom_range(0, 2 * span)) - CB'(span);
      q.cx = CB'($urandom_range(0, 2 * span)) - CB'(span);
      q.cy = CB'($urandom_range(0, 2 * span)) - CB'(span);
      s = $urandom_range(0, 64);
      t = $urandom_range(0, 64 - s);
      // Occasionally push past an edge to land just outside.
      if ($urandom_range(0, 3) == 0) t = t + int'($urandom_range(1, 8));
      q.px = q.ax + CB'((64'(s) * (64'(q.bx) - 64'(q.ax))
                       + 64'(t) * (64'(q.cx) - 64'(q.ax))) / 64);
      q.py = q.ay + CB'((64'(s) * (64'(q.by) - 64'(q.ay))
                       + 64'(t) * (64'(q.cy) - 64'(q.ay))) / 64);
      // Sometimes collapse the triangle onto a line.
      if ($urandom_range(0, 19) == 0) begin
         q.cx = CB'(q.ax + 2 * (q.bx - q.ax));
         q.cy = CB'(q.ay + 2 * (q.by - q.ay));
      end
      return q;
   endfunction

   function automatic tri_query_type noise_query();
      tri_query_type q;
      q.px = any_coord();
      q.py = any_coord();
      q.ax = any_coord();
      q.ay = any_coord();
      q.bx = any_coord();
      q.by = any_coord();
      q.cx = any_coord();
      q.cy = any_coord();
      return q;
   endfunction

   function automatic tri_query_type make_query(int px, int py, int ax, int ay,
                                                int bx, int by, int cx, int cy);
      tri_query_type q;
      q.px = CB'(px);
      q.py = CB'(py);
      q.ax = CB'(ax);
      q.ay = CB'(ay);
      q.bx = CB'(bx);
      q.by = CB'(by);
      q.cx = CB'(cx);
      q.cy = CB'(cy);
      return q;
   endfunction

   // Offers one request word at the falling edge and holds it until it is
   // accepted at a rising edge. Valid stays high into the next word when there
   // is no gap, so it is never lowered and raised in the same step.
   task automatic send_query(tri_query_type q, int gap);
      repeat (gap) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid      <= 1'b1;
      req.point_x    <= q.px;
      req.point_y    <= q.py;
      req.vertex_a_x <= q.ax;
      req.vertex_a_y <= q.ay;
      req.vertex_b_x <= q.bx;
      req.vertex_b_y <= q.by;
      req.vertex_c_x <= q.cx;
      req.vertex_c_y <= q.cy;
      do @(posedge clock); while (!req.ready);
      board.note_query(q);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   // Receiver: samples at the rising edge, changes ready at the falling edge.
   initial begin
      int stall;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            // Long hold-off, counted here, so that the pipeline fills up and
            // the sender sees ready drop.
            rsp.ready <= 1'b0;
            repeat (120) @(negedge clock);
            hold_rsp = 1'b0;
         end
         stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      tri_weights_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.status = rsp.status;
         got.wa     = rsp.weight_a;
         got.wb     = rsp.weight_b;
         got.wc     = rsp.weight_c;
         board.check_word(got);
      end
   end

   // Sender: directed corners first, then the random body.
   initial begin
      tri_query_type directed[$];
      int            sent;
      bit            calm;
      req.valid      = 1'b0;
      req.point_x    = '0;
      req.point_y    = '0;
      req.vertex_a_x = '0;
      req.vertex_a_y = '0;
      req.vertex_b_x = '0;
      req.vertex_b_y = '0;
      req.vertex_c_x = '0;
      req.vertex_c_y = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Unit right triangle scaled by 256: inside, vertices, edges, outside.
      directed.push_back(make_query(64, 64, 0, 0, 256, 0, 0, 256));
      directed.push_back(make_query(0, 0, 0, 0, 256, 0, 0, 256));
      directed.push_back(make_query(256, 0, 0, 0, 256, 0, 0, 256));
      directed.push_back(make_query(0, 256, 0, 0, 256, 0, 0, 256));
      directed.push_back(make_query(128, 128, 0, 0, 256, 0, 0, 256));
      directed.push_back(make_query(128, 0, 0, 0, 256, 0, 0, 256));
      directed.push_back(make_query(200, 200, 0, 0, 256, 0, 0, 256));
      directed.push_back(make_query(-1, 10, 0, 0, 256, 0, 0, 256));
      directed.push_back(make_query(10, -1, 0, 0, 256, 0, 0, 256));
      // Clockwise winding gives a negative determinant.
      directed.push_back(make_query(50, 60, 0, 0, 0, 256, 256, 0));
      // Uneven thirds, where truncation matters.
      directed.push_back(make_query(1, 1, 0, 0, 3, 0, 0, 3));
      // Coincident and collinear vertices.
      directed.push_back(make_query(5, 5, 7, 7, 7, 7, 7, 7));
      directed.push_back(make_query(5, 5, 0, 0, 10, 10, 20, 20));
      directed.push_back(make_query(0, 0, 0, 0, 0, 0, 100, 0));
      // Full-range triangles with extreme coordinates.
      directed.push_back(make_query(0, 0, -8388608, -8388608, 8388607, -8388608,
                                    -8388608, 8388607));
      directed.push_back(make_query(8388607, 8388607, -8388608, -8388608,
                                    8388607, -8388608, -8388608, 8388607));
      directed.push_back(make_query(-8388608, -8388608, -8388608, -8388608,
                                    8388607, -8388608, -8388608, 8388607));
      directed.push_back(make_query(-1, -1, -8388608, 8388607, 8388607,
                                    -8388608, 8388607, 8388607));
      directed.push_back(make_query(-8388608, 8388607, 8388607, -8388608,
                                    -8388608, -8388608, 8388607, 8388607));
      foreach (directed[i]) send_query(directed[i], 0);

      // Hold the sender until every expected word is back.
      drain_results();
      @(negedge clock);

      sent = 0;
      calm = 1'b0;
      while (sent < RANDOM_WORDS) begin
         if (sent == 300) hold_rsp = 1'b1;
         if (sent == 700) begin
            drain_results();
            @(negedge clock);
         end
         // Some stretches run back to back with no gaps at all.
         if (sent % 100 == 0) calm = ($urandom_range(0, 2) == 0);
         send_query(($urandom_range(0, 9) < 7) ? shaped_query() : noise_query(),
                    calm ? 0 : pick_gap());
         sent++;
      end
      req.valid <= 1'b0;
      sending_done = 1'b1;
   end

   // Normal end: all stimulus accepted, all results back, then a short wait
   // for any stray word at the pipeline depth.
   initial begin
      wait (sending_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0) begin
         $display("PASS barycentric_point_in_triangle");
      end else begin
         $display("FAIL barycentric_point_in_triangle");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL barycentric_point_in_triangle");
      $finish;
   end

endmodule

// File: filelist.f
rtl/bpt_pkg.sv
rtl/bpt_if.sv
rtl/bpt_front.sv
rtl/bpt_divider.sv
rtl/barycentric_point_in_triangle.sv
bench/barycentric_point_in_triangle_test.sv
